// ===== design/pr_pkg.sv =====
// ----------------------------------------------------------------------------
// pr_pkg
// Shared sizes, item codes and types of the PageRank power-iteration core.
// ----------------------------------------------------------------------------
`default_nettype none

package pr_pkg;

  // Store sizes.
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 8192;
  localparam int VADDR_W      = $clog2(MAX_VERTICES);
  localparam int EADDR_W      = $clog2(MAX_EDGES);

  // Field widths fixed by the item format.
  localparam int RANK_W   = 32;
  localparam int DAMP_W   = 16;
  localparam int COUNT_W  = 11;
  localparam int DEG_W    = 14;
  localparam int ROUNDS_W = 8;
  localparam int TGT_W    = 10;
  localparam int DIVD_W   = 33;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // Input item modes.
  localparam logic [1:0] MODE_LOAD_VERTEX = 2'd0;
  localparam logic [1:0] MODE_LOAD_EDGE   = 2'd1;
  localparam logic [1:0] MODE_START       = 2'd2;
  localparam logic [1:0] MODE_READ        = 2'd3;

  // Result kinds.
  localparam logic KIND_RANK = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Divider result as seen by the sequencer.
  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/pagerank_power_iteration_core.sv =====
// ----------------------------------------------------------------------------
// pagerank_power_iteration_core
// PageRank power iteration over a compressed graph in Q0.32 fixed point.
// ----------------------------------------------------------------------------
// A start item first computes 1/N and the constant term with the shared
// divider, writes 1/N into all 1024 rank entries, then runs each round:
// clear N sums, visit each active vertex (with a nonzero out-degree, divide
// its rank by the degree, then walk its edges and add the share into the
// sum of each active target by a read-modify-write of the sum memory), and
// update N ranks. A read or a finished run also waits while the result word
// is held. The shared divider and the single read port of each memory bound
// the speed of these steps. The block takes no item while a start item is
// running.
`default_nettype none

module pagerank_power_iteration_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // vertex[9:0], first_slot[22:10], edge_count[36:23], edge_slot[49:37],
  // target[59:50], rounds[67:60], zero fill
  input  wire logic [71:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // which_vertex[9:0], rank_value[41:10], zero fill
  output logic [47:0]      m_axis_tdata,
  // kind[0]
  output logic             m_axis_tuser
);

  localparam int VW = pr_pkg::VADDR_W;
  localparam int EW = pr_pkg::EADDR_W;
  localparam int RW = pr_pkg::RANK_W;
  localparam int CW = pr_pkg::COUNT_W;
  localparam int DW = pr_pkg::DEG_W;

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD     = 5'd1;
  localparam logic [4:0] S_DONE   = 5'd2;
  localparam logic [4:0] S_DINIT  = 5'd3;
  localparam logic [4:0] S_DALPHA = 5'd4;
  localparam logic [4:0] S_FILL   = 5'd5;
  localparam logic [4:0] S_ROUND  = 5'd6;
  localparam logic [4:0] S_CLR    = 5'd7;
  localparam logic [4:0] S_V_RD   = 5'd8;
  localparam logic [4:0] S_V_DAT  = 5'd9;
  localparam logic [4:0] S_V_DIV  = 5'd10;
  localparam logic [4:0] S_E_RD   = 5'd11;
  localparam logic [4:0] S_E_T    = 5'd12;
  localparam logic [4:0] S_E_S    = 5'd13;
  localparam logic [4:0] S_U_RD   = 5'd14;
  localparam logic [4:0] S_U_MUL  = 5'd15;
  localparam logic [4:0] S_U_WR   = 5'd16;

  // Input fields.
  logic [VW-1:0]              in_vertex;
  logic [EW-1:0]              in_offset;
  logic [DW-1:0]              in_count;
  logic [EW-1:0]              in_slot;
  logic [pr_pkg::TGT_W-1:0]   in_target;
  logic [pr_pkg::ROUNDS_W-1:0] in_rounds;
  logic                        in_acc;

  assign in_vertex = s_axis_tdata[9:0];
  assign in_offset = s_axis_tdata[22:10];
  assign in_count  = s_axis_tdata[36:23];
  assign in_slot   = s_axis_tdata[49:37];
  assign in_target = s_axis_tdata[59:50];
  assign in_rounds = s_axis_tdata[67:60];

  logic [4:0]                  state;
  logic [pr_pkg::DAMP_W-1:0]   damping;
  logic [CW-1:0]               vertex_count;
  logic [CW-1:0]               n_act;
  logic [CW-1:0]               n_calc;
  logic [pr_pkg::ROUNDS_W-1:0] rounds;
  logic                        started;
  logic [RW-1:0]               init_rank;
  logic [pr_pkg::DIVD_W-1:0]   alpha;
  logic [VW-1:0]               fidx;
  logic [CW-1:0]               vidx;
  logic [EW-1:0]               cur_off;
  logic [DW-1:0]               cur_deg;
  logic [DW-1:0]               kidx;
  logic [RW-1:0]               share;
  logic [VW-1:0]               tgt_reg;
  logic [VW-1:0]               rd_vertex;
  logic [47:0]                 prod;

  logic                        out_valid;
  logic                        out_kind;
  logic [VW-1:0]               out_vertex;
  logic [RW-1:0]               out_rank;
  logic                        out_free;

  // Memory ports.
  logic [EW-1:0]               off_rdata;
  logic [DW-1:0]               deg_rdata;
  logic [pr_pkg::TGT_W-1:0]    tgt_rdata;
  logic [RW-1:0]               rank_rdata;
  logic [RW-1:0]               sum_rdata;
  logic                        vtx_we;
  logic                        tgt_we;
  logic [EW-1:0]               tgt_raddr;
  logic                        rank_we;
  logic [VW-1:0]               rank_waddr;
  logic [RW-1:0]               rank_wdata;
  logic [VW-1:0]               rank_raddr;
  logic                        sum_we;
  logic [VW-1:0]               sum_waddr;
  logic [RW-1:0]               sum_wdata;
  logic [VW-1:0]               sum_raddr;

  // Divider hookup.
  logic                        div_start;
  logic [pr_pkg::DIVD_W-1:0]   div_dividend;
  logic [DW-1:0]               div_divisor;
  pr_pkg::div_res_t            div_res;

  // Arithmetic helpers.
  logic [RW:0]                 sum_add;
  logic [RW+1:0]               rank_add;
  logic                        tgt_active;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // Active vertex count, clamped to the range 1 to the store size.
  always_comb begin
    if (vertex_count == '0) begin
      n_calc = CW'(1);
    end else if (vertex_count > CW'(pr_pkg::MAX_VERTICES)) begin
      n_calc = CW'(pr_pkg::MAX_VERTICES);
    end else begin
      n_calc = vertex_count;
    end
  end

  assign sum_add    = {1'b0, sum_rdata} + {1'b0, share};
  assign rank_add   = {1'b0, alpha} + {2'b00, prod[47:16]};
  assign tgt_active = {1'b0, tgt_rdata} < n_act;

  // Memory address and write selection.
  always_comb begin
    vtx_we     = in_acc && (s_axis_tuser == pr_pkg::MODE_LOAD_VERTEX);
    tgt_we     = in_acc && (s_axis_tuser == pr_pkg::MODE_LOAD_EDGE);
    tgt_raddr  = cur_off + kidx[EW-1:0];
    rank_raddr = (state == S_IDLE) ? in_vertex :
                 (state == S_RD)   ? rd_vertex : vidx[VW-1:0];
    rank_we    = (state == S_FILL) || (state == S_U_WR);
    rank_waddr = (state == S_FILL) ? fidx : vidx[VW-1:0];
    rank_wdata = (state == S_FILL) ? init_rank :
                 (rank_add[RW+1:RW] != 2'b00) ? pr_pkg::RANK_MAX : rank_add[RW-1:0];
    sum_raddr  = (state == S_E_T) ? tgt_rdata : vidx[VW-1:0];
    sum_we     = (state == S_CLR) || (state == S_E_S);
    sum_waddr  = (state == S_CLR) ? vidx[VW-1:0] : tgt_reg;
    sum_wdata  = (state == S_CLR) ? '0 :
                 sum_add[RW] ? pr_pkg::RANK_MAX : sum_add[RW-1:0];
  end

  // Divider requests.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b1, 32'd0};
    div_divisor  = {{(DW-CW){1'b0}}, n_calc};
    case (state)
      S_IDLE: begin
        div_start = in_acc && (s_axis_tuser == pr_pkg::MODE_START);
      end
      S_DINIT: begin
        div_start    = div_res.done;
        div_dividend = {(17'd65536 - {1'b0, damping}), 16'd0};
        div_divisor  = {{(DW-CW){1'b0}}, n_act};
      end
      S_V_DAT: begin
        div_start    = (deg_rdata != '0);
        div_dividend = {1'b0, rank_rdata};
        div_divisor  = deg_rdata;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  pr_ram #(.WIDTH(EW), .ADDR_W(VW)) u_off_ram (
    .clk (clk), .we (vtx_we), .waddr (in_vertex), .wdata (in_offset),
    .raddr (vidx[VW-1:0]), .rdata (off_rdata)
  );

  pr_ram #(.WIDTH(DW), .ADDR_W(VW)) u_deg_ram (
    .clk (clk), .we (vtx_we), .waddr (in_vertex), .wdata (in_count),
    .raddr (vidx[VW-1:0]), .rdata (deg_rdata)
  );

  pr_ram #(.WIDTH(pr_pkg::TGT_W), .ADDR_W(EW)) u_tgt_ram (
    .clk (clk), .we (tgt_we), .waddr (in_slot), .wdata (in_target),
    .raddr (tgt_raddr), .rdata (tgt_rdata)
  );

  pr_ram #(.WIDTH(RW), .ADDR_W(VW)) u_rank_ram (
    .clk (clk), .we (rank_we), .waddr (rank_waddr), .wdata (rank_wdata),
    .raddr (rank_raddr), .rdata (rank_rdata)
  );

  pr_ram #(.WIDTH(RW), .ADDR_W(VW)) u_sum_ram (
    .clk (clk), .we (sum_we), .waddr (sum_waddr), .wdata (sum_wdata),
    .raddr (sum_raddr), .rdata (sum_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      damping      <= 16'd55706;
      vertex_count <= CW'(1);
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        damping <= cfg_data;
      end else begin
        vertex_count <= cfg_data[CW-1:0];
      end
    end
  end

  // Sequencer and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (((state == S_RD) || (state == S_DONE)) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == pr_pkg::MODE_START) begin
              state <= S_DINIT;
            end else if (s_axis_tuser == pr_pkg::MODE_READ) begin
              state <= S_RD;
            end
          end
        end
        S_RD, S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DINIT: begin
          if (div_res.done) begin
            state <= S_DALPHA;
          end
        end
        S_DALPHA: begin
          if (div_res.done) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          started <= 1'b1;
          if (fidx == '1) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          state <= (rounds == '0) ? S_DONE : S_CLR;
        end
        S_CLR: begin
          if (vidx == n_act - CW'(1)) begin
            state <= S_V_RD;
          end
        end
        S_V_RD: begin
          state <= (vidx == n_act) ? S_U_RD : S_V_DAT;
        end
        S_V_DAT: begin
          state <= (deg_rdata == '0) ? S_V_RD : S_V_DIV;
        end
        S_V_DIV: begin
          if (div_res.done) begin
            state <= S_E_RD;
          end
        end
        S_E_RD: begin
          state <= (kidx == cur_deg) ? S_V_RD : S_E_T;
        end
        S_E_T: begin
          state <= tgt_active ? S_E_S : S_E_RD;
        end
        S_E_S: begin
          state <= S_E_RD;
        end
        S_U_RD: begin
          state <= (vidx == n_act) ? S_ROUND : S_U_MUL;
        end
        S_U_MUL: begin
          state <= S_U_WR;
        end
        S_U_WR: begin
          state <= S_U_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rd_vertex <= in_vertex;
        rounds    <= in_rounds;
        n_act     <= n_calc;
      end
      S_RD: begin
        if (out_free) begin
          out_kind   <= pr_pkg::KIND_RANK;
          out_vertex <= rd_vertex;
          out_rank   <= started ? rank_rdata : '0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_kind   <= pr_pkg::KIND_DONE;
          out_vertex <= '0;
          out_rank   <= '0;
        end
      end
      S_DINIT: begin
        init_rank <= div_res.quot[RW] ? pr_pkg::RANK_MAX : div_res.quot[RW-1:0];
        fidx      <= '0;
      end
      S_DALPHA: begin
        alpha <= div_res.quot;
      end
      S_FILL: begin
        fidx <= fidx + VW'(1);
      end
      S_ROUND: begin
        vidx <= '0;
        if (rounds != '0) begin
          rounds <= rounds - 8'd1;
        end
      end
      S_CLR: begin
        vidx <= (vidx == n_act - CW'(1)) ? '0 : vidx + CW'(1);
      end
      S_V_RD: begin
        if (vidx == n_act) begin
          vidx <= '0;
        end
      end
      S_V_DAT: begin
        cur_off <= off_rdata;
        cur_deg <= deg_rdata;
        kidx    <= '0;
        if (deg_rdata == '0) begin
          vidx <= vidx + CW'(1);
        end
      end
      S_V_DIV: begin
        share <= div_res.quot[RW-1:0];
      end
      S_E_RD: begin
        if (kidx == cur_deg) begin
          vidx <= vidx + CW'(1);
        end
      end
      S_E_T: begin
        tgt_reg <= tgt_rdata;
        if (!tgt_active) begin
          kidx <= kidx + DW'(1);
        end
      end
      S_E_S: begin
        kidx <= kidx + DW'(1);
      end
      S_U_MUL: begin
        prod <= damping * sum_rdata;
      end
      S_U_WR: begin
        vidx <= vidx + CW'(1);
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {6'd0, out_rank, out_vertex};

endmodule

`default_nettype wire

// ===== design/pr_div.sv =====
// ----------------------------------------------------------------------------
// pr_div
// Shared restoring divider: 33-bit dividend by 14-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [pr_pkg::DIVD_W-1:0]    dividend,
  input  wire logic [pr_pkg::DEG_W-1:0]     divisor,
  output pr_pkg::div_res_t                  res
);

  logic                         busy;
  logic                         done;
  logic [5:0]                   cnt;
  logic [pr_pkg::DEG_W-1:0]     rem;
  logic [pr_pkg::DEG_W-1:0]     dv;
  logic [pr_pkg::DIVD_W-1:0]    q;
  logic [pr_pkg::DEG_W:0]       shifted;
  logic [pr_pkg::DEG_W:0]       diff;
  logic                         ge;

  // One trial subtraction per cycle.
  assign shifted = {rem, q[pr_pkg::DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dv};
  assign diff    = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == 6'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(pr_pkg::DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath needs no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      if (ge) begin
        rem <= diff[pr_pkg::DEG_W-1:0];
      end else begin
        rem <= shifted[pr_pkg::DEG_W-1:0];
      end
      q <= {q[pr_pkg::DIVD_W-2:0], ge};
    end
  end

  assign res.done = done;
  assign res.quot = q;

endmodule

`default_nettype wire

// ===== design/pr_ram.sv =====
// ----------------------------------------------------------------------------
// pr_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/pr_checker.sv =====
// ----------------------------------------------------------------------------
// pr_checker
// Port-level checks of the PageRank core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A waiting result word holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word after reset");

  // Load words never raise a result.
  a_load: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[1] && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("load word produced a result");

  // Start and read words keep the input closed on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[1] |=> !s_axis_tready)
    else $error("input open right after a start or read word");

  // A run-finished word carries zero data.
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == pr_pkg::KIND_DONE) |-> m_axis_tdata == '0)
    else $error("run-finished word with nonzero data");

endmodule

bind pagerank_power_iteration_core pr_checker u_pr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PageRank power-iteration core.
// ----------------------------------------------------------------------------
// Directed and random load, start and read words are sent through the input
// stream. A bench-side copy of the graph and the fixed-point iteration predicts
// every done and rank word, and a small scoreboard checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic                      kind;
    logic [9:0]                vtx;
    logic [pr_pkg::RANK_W-1:0] rank;
  } rank_word_t;

  // Scoreboard: holds predicted result words and compares arrivals.
  class rank_scoreboard;
    rank_word_t pending[$];
    int         errors;

    function void note(rank_word_t w);
      pending.push_back(w);
    endfunction

    // Prints one mismatch line and counts it.
    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(rank_word_t got);
      rank_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word kind=%0d vertex=%0d rank=%h",
                         got.kind, got.vtx, got.rank));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      end
      if (got.vtx !== want.vtx) begin
        report($sformatf("vertex got %0d want %0d", got.vtx, want.vtx));
      end
      if (got.rank !== want.rank) begin
        report($sformatf("rank of %0d got %h want %h", want.vtx, got.rank, want.rank));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  pagerank_power_iteration_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  localparam logic CFG_DAMPING = 1'b0;
  localparam logic CFG_COUNT   = 1'b1;

  rank_scoreboard sb;

  // Bench copy of the graph and rank state.
  logic [15:0]               pm_damping;
  logic [10:0]               pm_count;
  logic [12:0]               pm_offset [pr_pkg::MAX_VERTICES];
  logic [13:0]               pm_degree [pr_pkg::MAX_VERTICES];
  logic [9:0]                pm_target [pr_pkg::MAX_EDGES];
  logic [pr_pkg::RANK_W-1:0] pm_rank   [pr_pkg::MAX_VERTICES];
  logic [pr_pkg::RANK_W-1:0] pm_sum    [pr_pkg::MAX_VERTICES];

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? pr_pkg::RANK_MAX : v[31:0];
  endfunction

  // Runs the given number of power-iteration rounds on the bench state.
  task automatic iterate_ranks(int rounds);
    int n;
    logic [63:0] alpha;
    logic [31:0] init;
    logic [31:0] share;
    int t;
    n = pm_count;
    if (n == 0) n = 1;
    if (n > pr_pkg::MAX_VERTICES) n = pr_pkg::MAX_VERTICES;
    init = sat32(64'h1_0000_0000 / n);
    alpha = ((64'd65536 - pm_damping) << 16) / n;
    for (int v = 0; v < pr_pkg::MAX_VERTICES; v++) pm_rank[v] = init;
    for (int r = 0; r < rounds; r++) begin
      for (int v = 0; v < pr_pkg::MAX_VERTICES; v++) pm_sum[v] = '0;
      for (int v = 0; v < n; v++) begin
        if (pm_degree[v] != 0) begin
          share = pm_rank[v] / pm_degree[v];
          for (int k = 0; k < pm_degree[v]; k++) begin
            t = pm_target[(pm_offset[v] + k) % pr_pkg::MAX_EDGES];
            if (t < n) pm_sum[t] = sat32({32'd0, pm_sum[t]} + share);
          end
        end
      end
      for (int v = 0; v < n; v++)
        pm_rank[v] = sat32(alpha + ((pm_damping * {32'd0, pm_sum[v]}) >> 16));
    end
  endtask

  // Predicts the result of one accepted input word.
  task automatic predict_word(logic [1:0] mode, logic [71:0] d);
    rank_word_t w;
    case (mode)
      pr_pkg::MODE_LOAD_VERTEX: begin
        pm_offset[d[9:0]] = d[22:10];
        pm_degree[d[9:0]] = d[36:23];
      end
      pr_pkg::MODE_LOAD_EDGE: pm_target[d[49:37]] = d[59:50];
      pr_pkg::MODE_START: begin
        iterate_ranks(d[67:60]);
        w.kind = pr_pkg::KIND_DONE; w.vtx = '0; w.rank = '0;
        sb.note(w);
      end
      default: begin
        w.kind = pr_pkg::KIND_RANK; w.vtx = d[9:0]; w.rank = pm_rank[d[9:0]];
        sb.note(w);
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000ms;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: a random wait before each word, then checking.
  initial begin
    rank_word_t got;
    int gap;
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready && !rst));
      got.kind = m_axis_tuser;
      got.vtx = m_axis_tdata[9:0];
      got.rank = m_axis_tdata[41:10];
      sb.check(got);
    end
  end

  // Sends one word, with a random gap in front.
  task automatic send_word(logic [1:0] mode, logic [71:0] d);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_word(mode, d);
  endtask

  function automatic logic [71:0] pack_word(int vtx, int off, int cnt, int slot,
                                            int tgt, int rounds);
    logic [71:0] d;
    d = '0;
    d[9:0] = 10'(vtx); d[22:10] = 13'(off); d[36:23] = 14'(cnt);
    d[49:37] = 13'(slot); d[59:50] = 10'(tgt); d[67:60] = 8'(rounds);
    return d;
  endfunction

  // Fills in the remaining fields with random noise.
  function automatic logic [71:0] noisy(logic [1:0] mode, logic [71:0] d);
    logic [71:0] r;
    r = 72'({$urandom, $urandom, $urandom}) & 72'h0F_FFFF_FFFF_FFFF_FFFF;
    case (mode)
      pr_pkg::MODE_LOAD_VERTEX: r[36:0] = d[36:0];
      pr_pkg::MODE_LOAD_EDGE:   r[59:37] = d[59:37];
      pr_pkg::MODE_START:       r[67:60] = d[67:60];
      default:                  r[9:0] = d[9:0];
    endcase
    return r;
  endfunction

  // Waits until all results are in, then lets the core settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_DAMPING) pm_damping = val;
    else pm_count = val[10:0];
  endtask

  // Loads a small random graph with every vertex and slot it can touch.
  task automatic load_graph(int n, int slots, int maxdeg);
    int off;
    for (int s = 0; s < slots; s++)
      send_word(pr_pkg::MODE_LOAD_EDGE, noisy(pr_pkg::MODE_LOAD_EDGE,
                pack_word(0, 0, 0, s, $urandom_range(0, n + 1), 0)));
    for (int v = 0; v < n; v++) begin
      off = $urandom_range(0, slots - maxdeg);
      send_word(pr_pkg::MODE_LOAD_VERTEX, noisy(pr_pkg::MODE_LOAD_VERTEX,
                pack_word(v, off, $urandom_range(0, maxdeg), 0, 0, 0)));
    end
  endtask

  int sent;
  int n;
  int pick;

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = pr_pkg::MODE_LOAD_VERTEX;
    pm_damping = 16'd55706; pm_count = 11'd1;
    for (int i = 0; i < pr_pkg::MAX_VERTICES; i++) begin
      pm_offset[i] = '0; pm_degree[i] = '0; pm_rank[i] = '0; pm_sum[i] = '0;
    end
    for (int i = 0; i < pr_pkg::MAX_EDGES; i++) pm_target[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: read before any start, zero rounds, extremes.
    send_word(pr_pkg::MODE_READ, pack_word(1023, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_LOAD_VERTEX, pack_word(0, 0, 1, 0, 0, 0));
    send_word(pr_pkg::MODE_LOAD_EDGE, pack_word(0, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_START, pack_word(0, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_READ, pack_word(0, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_START, pack_word(0, 0, 0, 0, 0, 3));
    send_word(pr_pkg::MODE_READ, pack_word(0, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_DAMPING, 16'hFFFF);
    write_reg(CFG_COUNT, 16'd3);
    // Vertex 2 wraps past the top slot; vertex 1 has an inactive target.
    send_word(pr_pkg::MODE_LOAD_EDGE, pack_word(0, 0, 0, 8191, 1, 0));
    send_word(pr_pkg::MODE_LOAD_EDGE, pack_word(0, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_LOAD_EDGE, pack_word(0, 0, 0, 1, 1023, 0));
    send_word(pr_pkg::MODE_LOAD_EDGE, pack_word(0, 0, 0, 2, 2, 0));
    send_word(pr_pkg::MODE_LOAD_VERTEX, pack_word(0, 2, 1, 0, 0, 0));
    send_word(pr_pkg::MODE_LOAD_VERTEX, pack_word(1, 1, 2, 0, 0, 0));
    send_word(pr_pkg::MODE_LOAD_VERTEX, pack_word(2, 8191, 2, 0, 0, 0));
    send_word(pr_pkg::MODE_START, pack_word(0, 0, 0, 0, 0, 4));
    for (int v = 0; v < 3; v++)
      send_word(pr_pkg::MODE_READ, pack_word(v, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_READ, pack_word(700, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_DAMPING, 16'h0000);
    write_reg(CFG_COUNT, 16'd2047);
    send_word(pr_pkg::MODE_START, pack_word(0, 0, 0, 0, 0, 0));
    send_word(pr_pkg::MODE_READ, pack_word(1023, 0, 0, 0, 0, 0));
    // A large degree once, to hit the top of the degree field.
    send_word(pr_pkg::MODE_LOAD_VERTEX, pack_word(1023, 8191, 16383, 0, 0, 0));
    send_word(pr_pkg::MODE_LOAD_VERTEX, pack_word(1023, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_COUNT, 16'd0);
    send_word(pr_pkg::MODE_START, pack_word(0, 0, 0, 0, 0, 255));
    send_word(pr_pkg::MODE_READ, pack_word(0, 0, 0, 0, 0, 0));
    drain();

    // Random part: phases of small graphs, runs and reads.
    sent = 0;
    while (sent < 850) begin
      n = $urandom_range(1, 12);
      write_reg(CFG_DAMPING, $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_COUNT, 16'(n));
      load_graph(n, 16, 6);
      sent += n + 16;
      for (int i = 0; i < 12; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2)
          send_word(pr_pkg::MODE_START, noisy(pr_pkg::MODE_START,
                    pack_word(0, 0, 0, 0, 0,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                              : $urandom_range(0, 6))));
        else if (pick == 2)
          send_word(pr_pkg::MODE_LOAD_EDGE, noisy(pr_pkg::MODE_LOAD_EDGE,
                    pack_word(0, 0, 0, $urandom_range(0, 15), $urandom, 0)));
        else
          send_word(pr_pkg::MODE_READ, noisy(pr_pkg::MODE_READ, pack_word(
                    $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, n - 1),
                    0, 0, 0, 0, 0)));
        sent++;
      end
      // Also exercise the upper bits of the wide fields on loaded words.
      send_word(pr_pkg::MODE_LOAD_EDGE, noisy(pr_pkg::MODE_LOAD_EDGE,
                pack_word(0, 0, 0, $urandom_range(4096, 8191), $urandom, 0)));
      send_word(pr_pkg::MODE_LOAD_VERTEX, noisy(pr_pkg::MODE_LOAD_VERTEX,
                pack_word($urandom_range(512, 1023), $urandom, 0, 0, 0, 0)));
      send_word(pr_pkg::MODE_LOAD_VERTEX, noisy(pr_pkg::MODE_LOAD_VERTEX,
                pack_word($urandom_range(512, 1023), 0, 16383, 0, 0, 0)));
      send_word(pr_pkg::MODE_LOAD_VERTEX, noisy(pr_pkg::MODE_LOAD_VERTEX,
                pack_word($urandom_range(512, 1023), 0, 8192, 0, 0, 0)));
      sent += 4;
      drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pr_pkg.sv
design/pr_div.sv
design/pr_ram.sv
design/pagerank_power_iteration_core.sv
design/pr_checker.sv
dv/tb_top.sv
